[rtl/rlm_pkg.sv]
// Shared constants, operation and status codes, and controller interface types.
package rlm_pkg;
	localparam int MAX_TXNS = 32;
	localparam int TXN_W = 5;
	localparam int LOCK_ENTRIES = 64;
	localparam int ENT_W = 6;
	localparam int CHAIN_LIMIT = 100;
	localparam int STEP_W = 7;
	localparam int KEY_W = 39;

	localparam logic [2:0] OP_BEGIN = 3'd0;
	localparam logic [2:0] OP_IS_ACTIVE = 3'd1;
	localparam logic [2:0] OP_ACQ_SH = 3'd2;
	localparam logic [2:0] OP_ACQ_EX = 3'd3;
	localparam logic [2:0] OP_REG_WAIT = 3'd4;
	localparam logic [2:0] OP_COMMIT = 3'd5;
	localparam logic [2:0] OP_ABORT = 3'd6;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_CONFLICT = 3'd1;
	localparam logic [2:0] ST_DEADLOCK = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_IN_USE = 3'd4;

	typedef struct packed {
		logic load;
		logic rd;
		logic decide;
		logic walk;
		logic finish;
	} rlm_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic need_walk;
		logic walk_done;
		logic out_busy;
	} rlm_stat_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [MAX_TXNS-1:0] holders;
		logic excl;
	} rlm_entry_t;
endpackage

[rtl/rlm_ctrl.sv]
// Sequencing state machine for the lock manager.
module rlm_ctrl import rlm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [2:0] operation,
	output logic in_stall,
	output rlm_cmd_t cmd,
	input rlm_stat_t stat
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_SCAN_END = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_WALK = 3'd4;
	localparam logic [2:0] S_REL = 3'd5;
	localparam logic [2:0] S_REL_END = 3'd6;
	localparam logic [2:0] S_FIN = 3'd7;

	logic [2:0] state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					case (operation) inside
						OP_ACQ_SH, OP_ACQ_EX: state_d = S_SCAN;
						OP_COMMIT, OP_ABORT: state_d = S_REL;
						default: state_d = S_FIN;
					endcase
				end
			end
			S_SCAN: begin
				cmd.rd = 1'b1;
				if (stat.idx_last) state_d = S_SCAN_END;
			end
			S_SCAN_END: state_d = S_DECIDE;
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = stat.need_walk ? S_WALK : S_FIN;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_done) state_d = S_FIN;
			end
			S_REL: begin
				cmd.rd = 1'b1;
				if (stat.idx_last) state_d = S_REL_END;
			end
			S_REL_END: state_d = S_FIN;
			S_FIN: begin
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

[rtl/rlm_datapath.sv]
// Lock table, waits-for table, transaction state and result register.
module rlm_datapath import rlm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input rlm_cmd_t cmd,
	output rlm_stat_t stat,
	input logic [2:0] operation,
	input logic [TXN_W-1:0] txn_id,
	input logic [7:0] table_id,
	input logic [30:0] row_id,
	input logic [TXN_W-1:0] wait_target_in,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] status,
	output logic [TXN_W-1:0] txn_out,
	output logic [TXN_W-1:0] blocker_out,
	output logic active_flag
);
	rlm_entry_t mem [LOCK_ENTRIES];
	logic [LOCK_ENTRIES-1:0] ent_valid_q;
	logic [MAX_TXNS-1:0] wait_vld_q;
	logic [TXN_W-1:0] wait_tgt [MAX_TXNS];
	logic [MAX_TXNS-1:0] active_q;
	logic [TXN_W-1:0] next_id_q;

	logic [2:0] op_q;
	logic [TXN_W-1:0] txn_q, wt_q, cur_q;
	logic [KEY_W-1:0] key_q;
	logic [ENT_W-1:0] idx_q, rd_idx_s1, hit_idx_q, free_idx_q;
	logic rd_vld_s1;
	rlm_entry_t rd_s1;
	logic hit_q, free_q, hit_excl_q;
	logic [MAX_TXNS-1:0] hit_hold_q;
	logic [STEP_W-1:0] steps_q;
	logic [2:0] res_status_q;
	logic [TXN_W-1:0] res_blk_q;
	logic out_valid_q;

	logic is_acq, is_rel;
	logic [MAX_TXNS-1:0] tbit;
	logic found_all, found_oth;
	logic [TXN_W-1:0] low_all, low_oth;
	logic wr_en;
	logic [ENT_W-1:0] wr_idx;
	rlm_entry_t wr_data;
	logic set_valid, clr_valid;
	logic dec_wait;
	logic [TXN_W-1:0] dec_blk;
	logic [2:0] dec_status;
	logic [MAX_TXNS-1:0] rel_hold;
	logic walk_dead, walk_end;
	logic [TXN_W-1:0] walk_nxt;

	function automatic logic [TXN_W:0] lowest(input logic [MAX_TXNS-1:0] m);
		logic [TXN_W:0] r;
		r = '0;
		for (int h = MAX_TXNS - 1; h >= 0; h--) begin
			if (m[h]) r = {1'b1, TXN_W'(h)};
		end
		return r;
	endfunction

	assign is_acq = (op_q == OP_ACQ_SH) || (op_q == OP_ACQ_EX);
	assign is_rel = (op_q == OP_COMMIT) || (op_q == OP_ABORT);
	assign tbit = MAX_TXNS'(1) << txn_q;
	assign {found_all, low_all} = lowest(hit_hold_q);
	assign {found_oth, low_oth} = lowest(hit_hold_q & ~tbit);
	assign rel_hold = rd_s1.holders & ~tbit;

	always_comb begin
		dec_wait = 1'b0;
		dec_blk = '0;
		dec_status = ST_OK;
		wr_en = 1'b0;
		wr_idx = hit_idx_q;
		wr_data = '{key: key_q, holders: hit_hold_q, excl: hit_excl_q};
		set_valid = 1'b0;
		clr_valid = 1'b0;
		if (cmd.decide) begin
			if (!hit_q) begin
				if (!free_q) begin
					dec_status = ST_FULL;
				end else begin
					wr_en = 1'b1;
					set_valid = 1'b1;
					wr_idx = free_idx_q;
					wr_data = '{key: key_q, holders: tbit, excl: (op_q == OP_ACQ_EX)};
				end
			end else if (op_q == OP_ACQ_SH) begin
				if (!hit_excl_q) begin
					wr_en = 1'b1;
					wr_data.holders = hit_hold_q | tbit;
				end else if (found_all && low_all != txn_q) begin
					dec_wait = 1'b1;
					dec_blk = low_all;
				end
			end else begin
				if (hit_hold_q == tbit) begin
					wr_en = 1'b1;
					wr_data.excl = 1'b1;
				end else if (found_oth) begin
					dec_wait = 1'b1;
					dec_blk = low_oth;
				end
			end
		end else if (rd_vld_s1 && is_rel && ent_valid_q[rd_idx_s1]) begin
			wr_en = 1'b1;
			wr_idx = rd_idx_s1;
			wr_data = '{key: rd_s1.key, holders: rel_hold, excl: rd_s1.excl};
			clr_valid = (rel_hold == '0);
		end
	end

	assign walk_nxt = wait_tgt[cur_q];
	assign walk_dead = wait_vld_q[cur_q] && (walk_nxt == txn_q);
	assign walk_end = !wait_vld_q[cur_q] || walk_dead
		|| (steps_q == STEP_W'(CHAIN_LIMIT - 1));

	assign stat.idx_last = (idx_q == ENT_W'(LOCK_ENTRIES - 1));
	assign stat.need_walk = dec_wait;
	assign stat.walk_done = walk_end;
	assign stat.out_busy = out_valid_q && out_stall;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_idx] <= wr_data;
		if (cmd.rd) rd_s1 <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.decide && dec_wait) wait_tgt[txn_q] <= dec_blk;
		else if (cmd.finish && op_q == OP_REG_WAIT) wait_tgt[txn_q] <= wt_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			txn_q <= txn_id;
			wt_q <= wait_target_in;
			key_q <= {table_id, row_id};
		end
		rd_idx_s1 <= idx_q;
		if (rd_vld_s1 && is_acq && !hit_q && ent_valid_q[rd_idx_s1]
				&& rd_s1.key == key_q) begin
			hit_idx_q <= rd_idx_s1;
			hit_hold_q <= rd_s1.holders;
			hit_excl_q <= rd_s1.excl;
		end
		if (rd_vld_s1 && !free_q && !ent_valid_q[rd_idx_s1]) free_idx_q <= rd_idx_s1;
		if (cmd.decide) begin
			cur_q <= txn_q;
			res_blk_q <= dec_blk;
		end else if (cmd.walk) begin
			cur_q <= walk_nxt;
		end
		if (cmd.finish) begin
			txn_out <= (op_q == OP_BEGIN) ? next_id_q : '0;
			blocker_out <= is_acq ? res_blk_q : '0;
			active_flag <= (op_q == OP_IS_ACTIVE) && active_q[txn_q];
			if (op_q == OP_BEGIN) status <= active_q[next_id_q] ? ST_IN_USE : ST_OK;
			else status <= is_acq ? res_status_q : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= '0;
			wait_vld_q <= '0;
			active_q <= '0;
			next_id_q <= '0;
			idx_q <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			steps_q <= '0;
			res_status_q <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd;
			if (cmd.load) begin
				idx_q <= '0;
				hit_q <= 1'b0;
				free_q <= 1'b0;
			end else if (cmd.rd) begin
				idx_q <= stat.idx_last ? '0 : idx_q + 1'b1;
			end
			if (rd_vld_s1 && is_acq && ent_valid_q[rd_idx_s1] && rd_s1.key == key_q)
				hit_q <= 1'b1;
			if (rd_vld_s1 && !ent_valid_q[rd_idx_s1]) free_q <= 1'b1;
			if (set_valid) ent_valid_q[wr_idx] <= 1'b1;
			if (clr_valid) ent_valid_q[wr_idx] <= 1'b0;
			if (cmd.decide) begin
				res_status_q <= dec_status;
				steps_q <= '0;
				if (dec_wait) wait_vld_q[txn_q] <= 1'b1;
			end
			if (cmd.walk) begin
				steps_q <= steps_q + 1'b1;
				if (walk_end) res_status_q <= walk_dead ? ST_DEADLOCK : ST_CONFLICT;
				if (walk_dead) wait_vld_q[txn_q] <= 1'b0;
			end
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (cmd.finish) begin
				case (op_q)
					OP_BEGIN: begin
						next_id_q <= next_id_q + 1'b1;
						active_q[next_id_q] <= 1'b1;
					end
					OP_REG_WAIT: wait_vld_q[txn_q] <= 1'b1;
					OP_COMMIT, OP_ABORT: begin
						wait_vld_q[txn_q] <= 1'b0;
						active_q[txn_q] <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

[rtl/row_lock_manager_deadlock_check_unit.sv]
// Top level of the row lock manager with waits-for deadlock check.
// Begin, is_active, register_wait and undefined codes go from idle straight to finish.
// Acquires scan the 64-entry lock table one entry a cycle through its single
// read port, then decide, with up to 100 waits-for steps when the request waits.
// Commit and abort sweep the table likewise. One item at a time.
// Reset clears the active mask, id counter, entry valid bits and wait bits.
module row_lock_manager_deadlock_check_unit import rlm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] operation,
	input logic [TXN_W-1:0] txn_id,
	input logic [7:0] table_id,
	input logic [30:0] row_id,
	input logic [TXN_W-1:0] wait_target_in,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] status,
	output logic [TXN_W-1:0] txn_out,
	output logic [TXN_W-1:0] blocker_out,
	output logic active_flag
);
	rlm_cmd_t cmd;
	rlm_stat_t stat;

	rlm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.operation(operation),
		.in_stall(in_stall),
		.cmd(cmd),
		.stat(stat)
	);

	rlm_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.operation(operation),
		.txn_id(txn_id),
		.table_id(table_id),
		.row_id(row_id),
		.wait_target_in(wait_target_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.txn_out(txn_out),
		.blocker_out(blocker_out),
		.active_flag(active_flag)
	);
endmodule
